// ===== sv/pnorm_pkg.sv =====
// ----------------------------------------------------------------------------
// pnorm_pkg
// Shared types, constants and arithmetic helpers for the pixel normaliser.
// ----------------------------------------------------------------------------
package pnorm_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned MeanW    = 16;
  localparam int unsigned InvW     = 24;
  localparam int unsigned CountW   = 21;
  localparam int unsigned PosW     = 20;
  localparam int unsigned ValueW   = 24;
  localparam int unsigned DiffW    = 17;
  localparam int unsigned ProdW    = 42;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned NumCh    = 3;
  localparam int unsigned RoundSh  = 12;

  // The counter spans 2^20 positions, which also bounds the pixel count.
  localparam logic [CountW-1:0] CountMax   = CountW'(1 << PosW);
  localparam logic [InvW-1:0]   InvStdRst  = InvW'(65536);

  typedef enum logic [CfgIdxW-1:0] {
    REG_MEAN_CH0    = 3'd0,
    REG_MEAN_CH1    = 3'd1,
    REG_MEAN_CH2    = 3'd2,
    REG_INV_STD_CH0 = 3'd3,
    REG_INV_STD_CH1 = 3'd4,
    REG_INV_STD_CH2 = 3'd5,
    REG_SWAP_MODE   = 3'd6,
    REG_PIXEL_COUNT = 3'd7
  } cfg_idx_e;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic signed [ProdW-1:0]  prod_t;

  // Rounds a Q16.24 product to Q12.12 (ties towards plus infinity) and
  // saturates it to the signed 24-bit range.
  function automatic value_t round_sat(input prod_t prod);
    prod_t                      biased;
    logic signed [ProdW-RoundSh-1:0] q;
    biased = prod + ProdW'(2048);
    q      = (ProdW-RoundSh)'(biased >>> RoundSh);
    if (q > (ProdW-RoundSh)'(8388607)) begin
      return value_t'(24'sh7FFFFF);
    end else if (q < -(ProdW-RoundSh)'(8388608)) begin
      return value_t'(24'sh800000);
    end else begin
      return value_t'(q[ValueW-1:0]);
    end
  endfunction

  // A zero count behaves as one; anything above the counter span is clipped.
  function automatic logic [CountW-1:0] eff_count(input logic [CountW-1:0] cnt);
    if (cnt == '0) begin
      return CountW'(1);
    end else if (cnt > CountMax) begin
      return CountMax;
    end else begin
      return cnt;
    end
  endfunction

endpackage

// ===== sv/pnorm_channel.sv =====
// ----------------------------------------------------------------------------
// pnorm_channel
// One colour channel: mean subtraction, multiply by the reciprocal, then
// rounding and saturation to signed Q12.12, all as combinational logic.
// ----------------------------------------------------------------------------
module pnorm_channel (
  input  logic [pnorm_pkg::ByteW-1:0]   byte_i,
  input  logic [pnorm_pkg::MeanW-1:0]   mean_i,
  input  logic [pnorm_pkg::InvW-1:0]    inv_std_i,
  output pnorm_pkg::value_t             value_o
);
  import pnorm_pkg::*;

  logic signed [DiffW-1:0] diff;
  prod_t                   prod;

  // Widen the byte to Q8.8 and take off the mean; the result fits 17 bits.
  assign diff = $signed({1'b0, byte_i, 8'b0}) - $signed({1'b0, mean_i});
  assign prod = ProdW'(diff) * ProdW'($signed({1'b0, inv_std_i}));

  assign value_o = round_sat(prod);

endmodule

// ===== sv/pixel_normalize_hwc_to_chw.sv =====
// ----------------------------------------------------------------------------
// pixel_normalize_hwc_to_chw
// Normalises packed three-byte pixels by per-channel mean and reciprocal
// standard deviation and emits the three plane values with a plane offset.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  --------  ---------  -------------------------  ------------------------------
//  s_axis    in         s_axis_tvalid/tready       tdata: three pixel bytes
//  m_axis    out        m_axis_tvalid/tready       tdata: three values, offset;
//                                                  tlast: last pixel of image
//  cfg       in         cfg_valid_i/cfg_ready_o    register index and data
//
// Each pixel passes through two register stages: the input register and the
// result register, with the mean subtraction, multiply, rounding and
// saturation between them. An accepted transaction waits in the input register
// until the result register can take it and leaves from the result register;
// one pixel can be taken in every cycle while the output is not stalled. The
// three channel multipliers set the length of the path between the stages.
// Each stage moves on whenever the stage after it is empty or is being
// emptied, so a stall at the output backs up through the pipeline one stage at
// a time. Reset clears the valid flags and the plane counter and restores the
// register defaults; the configuration port is always ready.
// ----------------------------------------------------------------------------
module pixel_normalize_hwc_to_chw (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration writes.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pnorm_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [pnorm_pkg::CfgDataW-1:0]    cfg_data_i,
  // Pixel input.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] byte_first, [15:8] byte_middle, [23:16] byte_third
  input  logic [23:0]                       s_axis_tdata,
  // Plane values output.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [23:0] plane0_value, [47:24] plane1_value, [71:48] plane2_value,
  // [91:72] plane_offset, [95:92] zero
  output logic [95:0]                       m_axis_tdata,
  output logic                              m_axis_tlast
);
  import pnorm_pkg::*;

  // Configuration registers.
  logic [MeanW-1:0]  mean_q    [NumCh];
  logic [InvW-1:0]   inv_std_q [NumCh];
  logic              swap_q;
  logic [CountW-1:0] count_q;

  // Handshakes and stage advance.
  logic s_fire;
  logic rdy1, rdy2;
  logic v1_q, v2_q;

  // Plane position counter and the values it gives the accepted pixel.
  logic [PosW-1:0]   pos_q, pos_d;
  logic [CountW-1:0] cnt_eff;
  logic              in_last;

  // Stage 1: swapped bytes and position.
  logic [ByteW-1:0]  b_d [NumCh];
  logic [ByteW-1:0]  b_q [NumCh];
  logic [PosW-1:0]   off1_q, off2_q;
  logic              last1_q, last2_q;

  // Channel results.
  value_t val_c [NumCh];
  value_t val2_q [NumCh];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCh; i++) begin
        mean_q[i]    <= '0;
        inv_std_q[i] <= InvStdRst;
      end
      swap_q  <= 1'b0;
      count_q <= CountMax;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_MEAN_CH0:    mean_q[0]    <= cfg_data_i[MeanW-1:0];
        REG_MEAN_CH1:    mean_q[1]    <= cfg_data_i[MeanW-1:0];
        REG_MEAN_CH2:    mean_q[2]    <= cfg_data_i[MeanW-1:0];
        REG_INV_STD_CH0: inv_std_q[0] <= cfg_data_i[InvW-1:0];
        REG_INV_STD_CH1: inv_std_q[1] <= cfg_data_i[InvW-1:0];
        REG_INV_STD_CH2: inv_std_q[2] <= cfg_data_i[InvW-1:0];
        REG_SWAP_MODE:   swap_q       <= cfg_data_i[0];
        REG_PIXEL_COUNT: count_q      <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or its contents leave in this cycle.
  assign rdy2          = !v2_q || m_axis_tready;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // The last flag is raised once the position reaches the effective count
  // minus one, which also covers a count lowered below the current position.
  assign cnt_eff = eff_count(count_q);
  assign in_last = ({1'b0, pos_q} + CountW'(1)) >= cnt_eff;
  assign pos_d   = in_last ? '0 : pos_q + PosW'(1);

  always_comb begin
    b_d[1] = s_axis_tdata[15:8];
    if (swap_q) begin
      b_d[0] = s_axis_tdata[23:16];
      b_d[2] = s_axis_tdata[7:0];
    end else begin
      b_d[0] = s_axis_tdata[7:0];
      b_d[2] = s_axis_tdata[23:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      pos_q <= '0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (s_fire) pos_q <= pos_d;
    end
  end

  // Payload registers load only with a valid transaction behind them.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      b_q     <= b_d;
      off1_q  <= pos_q;
      last1_q <= in_last;
    end
    if (rdy2 && v1_q) begin
      off2_q  <= off1_q;
      last2_q <= last1_q;
      val2_q  <= val_c;
    end
  end

  for (genvar c = 0; c < NumCh; c++) begin : g_ch
    pnorm_channel u_ch (
      .byte_i    (b_q[c]),
      .mean_i    (mean_q[c]),
      .inv_std_i (inv_std_q[c]),
      .value_o   (val_c[c])
    );
  end

  assign m_axis_tvalid = v2_q;
  assign m_axis_tlast  = last2_q;
  assign m_axis_tdata  = {4'b0, off2_q, val2_q[2], val2_q[1], val2_q[0]};

  // A pixel flagged last must send the counter back to the start of a plane.
  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && in_last) |=> (pos_q == '0))
    else $error("plane counter did not wrap after the last pixel");

  // Any other accepted pixel moves the counter on by one.
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && !in_last) |=> (pos_q == $past(pos_q) + PosW'(1)))
    else $error("plane counter did not advance");

  // With both stages full and the output stalled, no pixel may be taken.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while the pipeline is full");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pixel normaliser. A driver streams packed pixels
// from a backlog and a monitor compares each outgoing set of plane values with
// a prediction made when the pixel was accepted. The register settings change
// between phases while the block is quiet.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pnorm_pkg::*;

  // The plane counter spans 2^20 positions, which also caps the pixel count.
  localparam logic [20:0] PlaneSpan = 21'h100000;
  // Cycles allowed for the pipeline to run dry before the registers change.
  localparam int PipeSlack = 8;
  // Length of the deliberate output stall that backs the pipeline up.
  localparam int HoldCycles = 60;
  // Generous bound on the whole run.
  localparam int CycleLimit = 200000;
  localparam int RandPhases = 6;
  localparam int RandPerPhase = 75;

  typedef struct {
    logic [7:0] first;
    logic [7:0] middle;
    logic [7:0] third;
  } pixel_t;

  typedef struct {
    logic [23:0] plane0;
    logic [23:0] plane1;
    logic [23:0] plane2;
    logic [19:0] offset;
    logic        last;
  } plane_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic        m_axis_tlast;

  // Pixels waiting to be offered, and plane values waiting to come out.
  pixel_t        pixel_backlog[$];
  plane_result_t expected_planes[$];

  // The bench's own copy of the register file and the plane counter.
  logic [15:0] mean_q [3];
  logic [23:0] inv_q  [3];
  logic        swap_q;
  logic [20:0] count_q;
  logic [19:0] pos_q;

  // Register values to be written in the next configuration pass.
  logic [CfgDataW-1:0] reg_plan [2**CfgIdxW];

  logic   gaps_on = 1'b0;
  int     send_gap = 0;
  int     take_gap = 0;
  int     hold_req = 0;
  int     hold_seen = 0;
  int     hold_left = 0;
  int     mismatch_count = 0;
  int     results_seen = 0;
  pixel_t offered_px;

  pixel_normalize_hwc_to_chw uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset values of the registers and of the plane counter.
  initial begin
    for (int c = 0; c < 3; c++) begin
      mean_q[c] = 16'h0000;
      inv_q[c]  = 24'h010000;
    end
    swap_q  = 1'b0;
    count_q = PlaneSpan;
    pos_q   = '0;
  end

  // A zero count behaves as one, and anything beyond the counter span is
  // clipped to the span.
  function automatic logic [20:0] active_count(input logic [20:0] c);
    if (c == '0) begin
      return 21'd1;
    end
    if (c > PlaneSpan) begin
      return PlaneSpan;
    end
    return c;
  endfunction

  // The byte is widened to Q8.8, the mean taken off, and the difference scaled
  // by the Q8.16 reciprocal. The Q16.24 product is rounded to Q12.12 with ties
  // going upwards and then clamped to the signed 24-bit range.
  function automatic logic [23:0] scale_channel(input logic [7:0] b,
                                                 input logic [15:0] m,
                                                 input logic [23:0] k);
    longint d;
    longint p;
    longint q;
    d = longint'({b, 8'h00}) - longint'(m);
    p = d * longint'(k);
    q = (p + 2048) >>> 12;
    if (q > 8388607) begin
      q = 8388607;
    end else if (q < -8388608) begin
      q = -8388608;
    end
    return q[23:0];
  endfunction

  // Works out the plane values for an accepted pixel and advances the counter.
  task automatic predict_planes(input pixel_t px);
    plane_result_t r;
    logic [7:0]    ch0;
    logic [7:0]    ch2;
    ch0 = swap_q ? px.third : px.first;
    ch2 = swap_q ? px.first : px.third;
    r.plane0 = scale_channel(ch0, mean_q[0], inv_q[0]);
    r.plane1 = scale_channel(px.middle, mean_q[1], inv_q[1]);
    r.plane2 = scale_channel(ch2, mean_q[2], inv_q[2]);
    r.offset = pos_q;
    // A count lowered below the current position ends the image at once.
    r.last   = ({1'b0, pos_q} + 21'd1) >= active_count(count_q);
    pos_q    = r.last ? '0 : pos_q + 20'd1;
    expected_planes = {expected_planes, r};
  endtask

  // Mirrors a register write into the bench's copy of the register file.
  task automatic take_register(input cfg_idx_e r, input logic [CfgDataW-1:0] d);
    case (r)
      REG_MEAN_CH0:    mean_q[0] = d[15:0];
      REG_MEAN_CH1:    mean_q[1] = d[15:0];
      REG_MEAN_CH2:    mean_q[2] = d[15:0];
      REG_INV_STD_CH0: inv_q[0]  = d;
      REG_INV_STD_CH1: inv_q[1]  = d;
      REG_INV_STD_CH2: inv_q[2]  = d;
      REG_SWAP_MODE:   swap_q    = d[0];
      REG_PIXEL_COUNT: count_q   = d[20:0];
      default: ;
    endcase
  endtask

  function automatic void note_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] MISMATCH %s", $realtime, msg);
    end
  endfunction

  function automatic void check_field(input string what, input logic [23:0] want,
                                      input logic [23:0] got);
    if (got !== want) begin
      note_error($sformatf("result %0d %s: expected 0x%06h, got 0x%06h",
                           results_seen, what, want, got));
    end
  endfunction

  // Pixel driver. Each transaction is predicted at the edge where it is
  // accepted, then the next pixel is offered after a random pause if gaps are
  // on. The valid is worked out in a variable first so that it gets a single
  // update per edge, even when one pixel follows the next without a gap.
  always @(posedge clk) begin : pixel_driver
    logic offer;
    offer = s_axis_tvalid;
    if (!rst_n) begin
      offer = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_planes(offered_px);
        offer    = 1'b0;
        send_gap = gaps_on ? $urandom_range(0, 3) : 0;
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pixel_backlog.size() != 0) begin
          offered_px = pixel_backlog.pop_front();
          offer      = 1'b1;
          s_axis_tdata <= {offered_px.third, offered_px.middle, offered_px.first};
        end
      end
    end
    s_axis_tvalid <= offer;
  end

  // Result monitor. Every transaction on the output is matched against the
  // oldest prediction, field by field. With gaps on, the ready drops for a
  // random pause after each transaction, and for the whole of a long hold.
  always @(posedge clk) begin : plane_monitor
    plane_result_t got;
    plane_result_t want;
    if (!rst_n) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.plane0 = m_axis_tdata[23:0];
        got.plane1 = m_axis_tdata[47:24];
        got.plane2 = m_axis_tdata[71:48];
        got.offset = m_axis_tdata[91:72];
        got.last   = m_axis_tlast;
        if (expected_planes.size() == 0) begin
          note_error($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_planes.pop_front();
          check_field("plane0", want.plane0, got.plane0);
          check_field("plane1", want.plane1, got.plane1);
          check_field("plane2", want.plane2, got.plane2);
          check_field("offset", 24'(want.offset), 24'(got.offset));
          check_field("last", 24'(want.last), 24'(got.last));
        end
        results_seen++;
        take_gap = gaps_on ? $urandom_range(0, 3) : 0;
      end else if (take_gap > 0) begin
        take_gap--;
      end
      m_axis_tready <= (take_gap == 0) && (hold_left == 0);
    end
  end

  // Long output hold, counted here so that the sender keeps offering pixels
  // while the pipeline fills and the input is stalled.
  always @(posedge clk) begin : output_hold
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_left <= HoldCycles;
      hold_seen <= hold_req;
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void queue_pixel(input logic [7:0] f, input logic [7:0] m,
                                      input logic [7:0] t);
    pixel_t px;
    px.first  = f;
    px.middle = m;
    px.third  = t;
    pixel_backlog = {pixel_backlog, px};
  endfunction

  function automatic void plan_regs(input logic [23:0] m0, input logic [23:0] m1,
                                    input logic [23:0] m2, input logic [23:0] k0,
                                    input logic [23:0] k1, input logic [23:0] k2,
                                    input logic [23:0] sw, input logic [23:0] cnt);
    reg_plan[REG_MEAN_CH0]    = m0;
    reg_plan[REG_MEAN_CH1]    = m1;
    reg_plan[REG_MEAN_CH2]    = m2;
    reg_plan[REG_INV_STD_CH0] = k0;
    reg_plan[REG_INV_STD_CH1] = k1;
    reg_plan[REG_INV_STD_CH2] = k2;
    reg_plan[REG_SWAP_MODE]   = sw;
    reg_plan[REG_PIXEL_COUNT] = cnt;
  endfunction

  // Means lean towards whole-byte values and the extremes; unused upper data
  // bits are often set to show that they are ignored.
  function automatic logic [23:0] pick_mean();
    case ($urandom_range(0, 3))
      0:       return {8'($urandom), 16'($urandom)};
      1:       return {8'h00, 8'($urandom), 8'h00};
      2:       return 24'h00FFFF;
      default: return 24'hFF0000;
    endcase
  endfunction

  // Small reciprocals keep most values inside the Q12.12 range, so rounding
  // is exercised as well as clamping.
  function automatic logic [23:0] pick_inv();
    case ($urandom_range(0, 5))
      0, 1:    return 24'($urandom_range(0, 24'h03FFFF));
      2:       return 24'($urandom);
      3:       return 24'h000000;
      4:       return 24'h010000;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  // Short images give frequent last flags; a zero count and an oversized one
  // turn up now and then.
  function automatic logic [23:0] pick_count();
    case ($urandom_range(0, 5))
      0, 1, 2: return {3'($urandom), 21'($urandom_range(1, 40))};
      3:       return {3'($urandom), 21'($urandom_range(1, 3))};
      4:       return {3'($urandom), 21'h000000};
      default: return {3'($urandom), 1'b1, 20'($urandom)};
    endcase
  endfunction

  // Writes the whole planned register file, one transaction per register. The
  // valid stays high from one write to the next and drops after the last.
  task automatic write_registers();
    cfg_idx_e r;
    r = r.first();
    do begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= r;
      cfg_data_i  <= reg_plan[r];
      @(posedge clk);
      while (!cfg_ready_o) @(posedge clk);
      take_register(r, reg_plan[r]);
      r = r.next();
    end while (r != r.first());
    cfg_valid_i <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every pixel has gone in and every result has come out, then
  // waits out the PipeSlack margin as well.
  task automatic settle();
    while (pixel_backlog.size() != 0 || s_axis_tvalid || expected_planes.size() != 0) begin
      @(posedge clk);
    end
    repeat (PipeSlack) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unity scaling and a four-pixel image, back to back: the extremes of
    // every byte pass straight through and the counter wraps once.
    plan_regs(24'h0, 24'h0, 24'h0, 24'h010000, 24'h010000, 24'h010000, 24'h0, 24'h4);
    write_registers();
    queue_pixel(8'h00, 8'h00, 8'h00);
    queue_pixel(8'hFF, 8'hFF, 8'hFF);
    queue_pixel(8'h01, 8'h80, 8'hFE);
    queue_pixel(8'hAA, 8'h55, 8'h0F);
    queue_pixel(8'hF0, 8'h0F, 8'h3C);
    queue_pixel(8'h12, 8'h34, 8'h56);
    settle();

    // Byte swap, clamping at both ends, a zero reciprocal on channel 2 and a
    // zero pixel count, so that every pixel is the last one.
    gaps_on <= 1'b1;
    plan_regs(24'h00FFFF, 24'h000000, 24'h008000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000,
              24'h000001, 24'h000000);
    write_registers();
    queue_pixel(8'h00, 8'h00, 8'h00);
    queue_pixel(8'hFF, 8'hFF, 8'hFF);
    queue_pixel(8'hFF, 8'h7F, 8'h00);
    queue_pixel(8'h3C, 8'h01, 8'hC3);
    settle();

    // A count beyond the counter span is clipped; the tiny reciprocal on
    // channel 2 lands a positive difference exactly on a rounding tie.
    plan_regs(24'h001234, 24'h000080, 24'h000000, 24'h00C000, 24'h018000, 24'h000001,
              24'h000000, 24'hFFFFFF);
    write_registers();
    queue_pixel(8'h20, 8'h40, 8'h08);
    queue_pixel(8'hC0, 8'h02, 8'h08);
    queue_pixel(8'h7F, 8'hFE, 8'h10);
    queue_pixel(8'h81, 8'h00, 8'hFF);
    settle();

    // The count drops below the current position, so the next pixel closes
    // the image and the counter restarts; a negative tie rounds upwards.
    plan_regs(24'h001234, 24'h000080, 24'h00FF00, 24'h00C000, 24'h018000, 24'h000001,
              24'h000000, 24'h000002);
    write_registers();
    queue_pixel(8'h11, 8'h22, 8'hF7);
    queue_pixel(8'h33, 8'h44, 8'hF7);
    queue_pixel(8'h55, 8'h66, 8'h00);
    settle();

    // Random phases, each with fresh random settings. One runs without any
    // idling, and two start with a long output hold.
    for (int p = 0; p < RandPhases; p++) begin
      plan_regs(pick_mean(), pick_mean(), pick_mean(), pick_inv(), pick_inv(), pick_inv(),
                24'($urandom), pick_count());
      write_registers();
      gaps_on <= (p != 2);
      if (p == 0 || p == 4) begin
        hold_req <= hold_req + 1;
      end
      repeat (RandPerPhase) queue_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      settle();
    end

    if (expected_planes.size() != 0) begin
      note_error($sformatf("%0d results never arrived", expected_planes.size()));
    end
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== pixel_normalize_hwc_to_chw.f =====
sv/pnorm_pkg.sv
sv/pnorm_channel.sv
sv/pixel_normalize_hwc_to_chw.sv
tb/tb_top.sv
